// ----- rtl/bvls_pkg.sv -----
package bvls_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned COUNT_W   = 5;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // datapath commands
    typedef struct packed {
        logic load_op;     // capture the input beat, zero the index
        logic rd;          // issue a memory read at the index
        logic idx_inc;     // advance the walk index
        logic wr_append;   // write the value at the count, bump count
        logic hit_latch;   // record found at the entry last read
        logic shift_wr;    // write the read word one place down
        logic cnt_dec;     // drop the count by one
        logic cnt_clr;     // empty the list
        logic key_load;    // hold read word as insertion key, j = i
        logic ins_rd;      // read entry j-1
        logic ins_move;    // write entry j from read word, step j down
        logic ins_place;   // write key at j
    } t_cmd;

    typedef struct packed {
        logic idx_end;     // index has reached the count
        logic match;       // registered read word equals the value
        logic full;        // count at depth
        logic greater;     // registered read word above the key (signed)
        logic j_zero;      // insertion point at the head
    } t_sts;

endpackage

// ----- rtl/bvls_datapath.sv -----
module bvls_datapath #(
    parameter int unsigned DEPTH = bvls_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [bvls_pkg::OP_W-1:0]           i_operation,
    input  logic signed [bvls_pkg::VALUE_W-1:0] i_value,
    input  bvls_pkg::t_cmd                      i_cmd,
    output bvls_pkg::t_sts                      o_sts,
    output logic [bvls_pkg::OP_W-1:0]           o_op,
    output logic                                o_found,
    output logic [bvls_pkg::POS_W-1:0]          o_position,
    output logic [bvls_pkg::COUNT_W-1:0]        o_entry_count
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [bvls_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [bvls_pkg::VALUE_W-1:0] r_rd;
    logic [bvls_pkg::VALUE_W-1:0] r_val;
    logic [bvls_pkg::VALUE_W-1:0] r_key;
    logic [bvls_pkg::OP_W-1:0]    r_op;
    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                r_idx;
    logic [CW-1:0]                r_j;
    logic [CW-1:0]                r_pos;
    logic                         r_found;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [bvls_pkg::VALUE_W-1:0] wr_data;

    always_comb begin
        rd_addr = r_idx[AW-1:0];
        if (i_cmd.ins_rd) begin
            rd_addr = AW'(r_j - CW'(1));
        end
        wr_en   = 1'b0;
        wr_addr = r_cnt[AW-1:0];
        wr_data = r_val;
        if (i_cmd.wr_append) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift_wr) begin
            wr_en   = 1'b1;
            wr_addr = AW'(r_idx - CW'(2));
            wr_data = r_rd;
        end else if (i_cmd.ins_move) begin
            wr_en   = 1'b1;
            wr_addr = r_j[AW-1:0];
            wr_data = r_rd;
        end else if (i_cmd.ins_place) begin
            wr_en   = 1'b1;
            wr_addr = r_j[AW-1:0];
            wr_data = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd || i_cmd.ins_rd) begin
            r_rd <= r_mem[rd_addr];
        end
        if (i_cmd.load_op) begin
            r_val <= i_value;
        end
        if (i_cmd.key_load) begin
            r_key <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_idx   <= '0;
            r_j     <= '0;
            r_pos   <= '0;
            r_found <= 1'b0;
            r_op    <= '0;
        end else begin
            if (i_cmd.load_op) begin
                r_op    <= i_operation;
                r_idx   <= '0;
                r_pos   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.hit_latch) begin
                r_found <= 1'b1;
                r_pos   <= r_idx - CW'(1);
            end
            if (i_cmd.wr_append) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CW'(1);
            end else if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end
            if (i_cmd.key_load) begin
                r_j <= r_idx - CW'(1);
            end else if (i_cmd.ins_move) begin
                r_j <= r_j - CW'(1);
            end
        end
    end

    // the sort walk starts at entry 1, so an empty list must also end it
    always_comb begin
        o_sts.idx_end = (r_idx >= r_cnt);
        o_sts.match   = (r_rd == r_val);
        o_sts.full    = (r_cnt == CW'(DEPTH));
        o_sts.greater = $signed(r_rd) > $signed(r_key);
        o_sts.j_zero  = (r_j == '0);
    end

    assign o_op          = r_op;
    assign o_found       = r_found;
    assign o_position    = bvls_pkg::POS_W'(r_pos);
    assign o_entry_count = bvls_pkg::COUNT_W'(r_cnt);
endmodule

// ----- rtl/bvls_ctrl.sv -----
module bvls_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_overflow,
    input  logic [bvls_pkg::OP_W-1:0] i_op,
    input  bvls_pkg::t_sts            i_sts,
    output bvls_pkg::t_cmd            o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DISP  = 11'b00000000010,
        S_FRD   = 11'b00000000100,
        S_FCHK  = 11'b00000001000,
        S_SHRD  = 11'b00000010000,
        S_SHWR  = 11'b00000100000,
        S_SRD   = 11'b00001000000,
        S_SKEY  = 11'b00010000000,
        S_SCMP  = 11'b00100000000,
        S_SCHK  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovf, n_ovf;

    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_op = 1'b1;
                    n_ovf   = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_op) inside
                    bvls_pkg::OP_APPEND: begin
                        if (i_sts.full) n_ovf = 1'b1;
                        else o_cmd.wr_append = 1'b1;
                        n_state = S_DONE;
                    end
                    bvls_pkg::OP_REMOVE, bvls_pkg::OP_SEARCH: begin
                        n_state = S_FRD;
                    end
                    bvls_pkg::OP_SORT: begin
                        o_cmd.idx_inc = 1'b1;   // insertion starts at entry 1
                        n_state = S_SRD;
                    end
                    bvls_pkg::OP_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            // search walk: read entry idx, advance, compare next cycle
            S_FRD: begin
                if (i_sts.idx_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (i_sts.match) begin
                    o_cmd.hit_latch = 1'b1;
                    n_state = (i_op == bvls_pkg::OP_REMOVE) ? S_SHRD : S_DONE;
                end else begin
                    n_state = S_FRD;
                end
            end
            // close up: idx points one past the gap
            S_SHRD: begin
                if (i_sts.idx_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd.shift_wr = 1'b1;
                n_state = S_SHRD;
            end
            // insertion sort: idx is i
            S_SRD: begin
                if (i_sts.idx_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SKEY;
                end
            end
            S_SKEY: begin
                o_cmd.key_load = 1'b1;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (i_sts.j_zero) begin
                    o_cmd.ins_place = 1'b1;
                    n_state = S_SRD;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_sts.greater) begin
                    o_cmd.ins_move = 1'b1;
                    n_state = S_SCMP;
                end else begin
                    o_cmd.ins_place = 1'b1;
                    n_state = S_SRD;
                end
            end
            S_DONE: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_overflow  = r_ovf;
endmodule

// ----- rtl/bounded_value_list_store_unit.sv -----
// Bounded value list store: an ordered list of up to DEPTH signed 32-bit
// values, kept in insertion order from the head until a sort reorders them.
// Input channel (i_in_valid / o_in_ready) carries one operation a beat:
// append, remove first match, search, sort ascending or clear, with a value.
// Output channel (o_out_valid / i_out_ready) returns one result beat per
// input beat: found, position, entry count and overflow.
// Append and clear go straight from dispatch to the result; search and remove
// walk the entries from the head, reading and then comparing each (remove
// then reads each later entry and writes it back one place down); sort is an
// insertion sort that reads each key, then reads and moves the greater entries
// before it. The single-port memory read and compare loop sets the pace.
// One item is handled at a time: a new beat is taken only once the result
// beat has been accepted. A stalled receiver holds the result steady.
// Reset empties the list at once; no clearing pass is needed, as entries at
// or beyond the count are never read.
module bounded_value_list_store_unit #(
    parameter int unsigned DEPTH = bvls_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [bvls_pkg::OP_W-1:0]           i_operation,
    input  logic signed [bvls_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [bvls_pkg::POS_W-1:0]          o_position,
    output logic [bvls_pkg::COUNT_W-1:0]        o_entry_count,
    output logic                                o_overflow
);
    bvls_pkg::t_cmd              cmd;
    bvls_pkg::t_sts              sts;
    logic [bvls_pkg::OP_W-1:0]   op;

    // sequence each operation
    bvls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_overflow  (o_overflow),
        .i_op        (op),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // hold the list, count and result fields
    bvls_datapath #(.DEPTH(DEPTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_op          (op),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );
endmodule

// ----- test/list_store_checker.sv -----
`timescale 1ns / 1ps

module list_store_checker #(
    parameter int unsigned DEPTH = bvls_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [bvls_pkg::OP_W-1:0]           i_operation,
    input  logic signed [bvls_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_found,
    input  logic [bvls_pkg::POS_W-1:0]          i_position,
    input  logic [bvls_pkg::COUNT_W-1:0]        i_entry_count,
    input  logic                                i_overflow,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct packed {
        logic                         found;
        logic [bvls_pkg::POS_W-1:0]   position;
        logic [bvls_pkg::COUNT_W-1:0] entry_count;
        logic                         overflow;
    } t_result;

    logic signed [bvls_pkg::VALUE_W-1:0] held_values[DEPTH];
    int unsigned                         held_n;
    t_result                             awaited_results[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic t_result apply_operation(input logic [bvls_pkg::OP_W-1:0] op,
                                                input logic signed [bvls_pkg::VALUE_W-1:0] v);
        t_result                             r;
        int                                  hit;
        logic signed [bvls_pkg::VALUE_W-1:0] key;
        int                                  j;
        r   = '0;
        hit = -1;
        if (op == bvls_pkg::OP_REMOVE || op == bvls_pkg::OP_SEARCH) begin
            for (int i = 0; i < held_n; i++) begin
                if (hit < 0 && held_values[i] == v) hit = i;
            end
        end
        case (op)
            bvls_pkg::OP_APPEND: begin
                if (held_n < DEPTH) begin
                    held_values[held_n] = v;
                    held_n++;
                end else begin
                    r.overflow = 1'b1;
                end
            end
            bvls_pkg::OP_REMOVE, bvls_pkg::OP_SEARCH: begin
                if (hit >= 0) begin
                    r.found    = 1'b1;
                    r.position = hit[bvls_pkg::POS_W-1:0];
                    if (op == bvls_pkg::OP_REMOVE) begin
                        for (int i = hit; i + 1 < held_n; i++) held_values[i] = held_values[i+1];
                        held_n--;
                    end
                end
            end
            bvls_pkg::OP_SORT: begin
                for (int i = 1; i < held_n; i++) begin
                    key = held_values[i];
                    j   = i;
                    while (j > 0 && held_values[j-1] > key) begin
                        held_values[j] = held_values[j-1];
                        j--;
                    end
                    held_values[j] = key;
                end
            end
            bvls_pkg::OP_CLEAR: held_n = 0;
            default: ;
        endcase
        r.entry_count = held_n[bvls_pkg::COUNT_W-1:0];
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            held_n = 0;
            awaited_results.delete();
        end else begin
            // predict on the input beat before checking, as a result can only
            // come in a later cycle than its own beat
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(apply_operation(i_operation, i_value));
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_found !== want.found)
                        report_mismatch("found", i_found, want.found);
                    if (i_position !== want.position)
                        report_mismatch("position", i_position, want.position);
                    if (i_entry_count !== want.entry_count)
                        report_mismatch("entry_count", i_entry_count, want.entry_count);
                    if (i_overflow !== want.overflow)
                        report_mismatch("overflow", i_overflow, want.overflow);
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned DEPTH = bvls_pkg::DEPTH_DEF;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [bvls_pkg::OP_W-1:0]           operation = bvls_pkg::OP_APPEND;
    logic signed [bvls_pkg::VALUE_W-1:0] value = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic                                found;
    logic [bvls_pkg::POS_W-1:0]          position;
    logic [bvls_pkg::COUNT_W-1:0]        entry_count;
    logic                                overflow;
    int                                  fail_count;
    int                                  pending;

    // receiver behaviour, steered by the stimulus process
    bit                        calm_phase = 1'b0;
    bit                        hold_off_request = 1'b0;

    // recent values, reused so that remove and search actually hit
    logic signed [bvls_pkg::VALUE_W-1:0] recent_values[$];

    always #4 i_clk = ~i_clk;

    bounded_value_list_store_unit #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_operation   (operation),
        .i_value       (value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_found       (found),
        .o_position    (position),
        .o_entry_count (entry_count),
        .o_overflow    (overflow)
    );

    list_store_checker #(.DEPTH(DEPTH)) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_operation   (operation),
        .i_value       (value),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_found       (found),
        .i_position    (position),
        .i_entry_count (entry_count),
        .i_overflow    (overflow),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Offer one beat at the falling edge and hold it until the rising edge
    // that accepts it. Valid stays high when a next beat follows at once.
    task automatic send_beat(input logic [bvls_pkg::OP_W-1:0] op,
                             input logic signed [bvls_pkg::VALUE_W-1:0] v,
                             input bit allow_gap);
        int gap;
        if (allow_gap && !calm_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        operation <= op;
        value     <= v;
        in_valid  <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (recent_values.size() > 24) void'(recent_values.pop_front());
        recent_values.push_back(v);
    endtask

    function automatic logic signed [bvls_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2:       return $signed($urandom_range(0, 6)) - 3;
            default: return recent_values.size() == 0 ? $urandom()
                        : recent_values[$urandom_range(0, recent_values.size() - 1)];
        endcase
    endfunction

    function automatic logic [bvls_pkg::OP_W-1:0] pick_operation();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 38) return bvls_pkg::OP_APPEND;
        if (roll < 58) return bvls_pkg::OP_REMOVE;
        if (roll < 80) return bvls_pkg::OP_SEARCH;
        if (roll < 90) return bvls_pkg::OP_SORT;
        if (roll < 95) return bvls_pkg::OP_CLEAR;
        return bvls_pkg::OP_W'($urandom_range(5, 7));    // unused codes are ignored
    endfunction

    // Receiver: random stall bursts, a long hold-off on request, none when calm.
    initial begin
        int burst;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                out_ready <= 1'b0;
                for (int c = 0; c < 300; c++) @(negedge i_clk);
                hold_off_request = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 15);
                out_ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic signed [bvls_pkg::VALUE_W-1:0] directed_values[6];
        directed_values = '{32'sh80000000, 32'sh7fffffff, 0, -1, 1, 32'sh55555555};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, every operation, misses, duplicates, overflow.
        send_beat(bvls_pkg::OP_SEARCH, 5, 0);       // search in an empty list
        send_beat(bvls_pkg::OP_REMOVE, 5, 0);       // remove with no match
        send_beat(bvls_pkg::OP_SORT, 0, 0);         // sort of nothing
        send_beat(bvls_pkg::OP_APPEND, 7, 0);
        send_beat(bvls_pkg::OP_SORT, 0, 0);         // sort of one entry
        foreach (directed_values[k]) send_beat(bvls_pkg::OP_APPEND, directed_values[k], 0);
        send_beat(bvls_pkg::OP_APPEND, -1, 0);      // duplicate value
        send_beat(bvls_pkg::OP_SEARCH, -1, 0);      // nearest the head wins
        send_beat(bvls_pkg::OP_REMOVE, -1, 0);
        send_beat(bvls_pkg::OP_SEARCH, 32'sh55555555, 0);
        send_beat(bvls_pkg::OP_SORT, 0, 0);
        send_beat(bvls_pkg::OP_SEARCH, 32'sh80000000, 0);
        send_beat(bvls_pkg::OP_W'(5), 1, 0);
        send_beat(bvls_pkg::OP_W'(7), 1, 0);
        for (int k = 0; k < DEPTH; k++) send_beat(bvls_pkg::OP_APPEND, $urandom(), 0); // overfill
        send_beat(bvls_pkg::OP_SORT, 0, 0);         // full-length sort
        send_beat(bvls_pkg::OP_CLEAR, 0, 0);

        // Long receiver hold-off while the sender keeps offering beats.
        hold_off_request = 1'b1;
        for (int k = 0; k < 6; k++) send_beat(pick_operation(), pick_value(), 0);

        // Random part; calm final stretch without any idling.
        for (int n = 0; n < 1650; n++) begin
            if (n == 1450) calm_phase = 1'b1;
            if (n == 700) begin
                // pause until every expected result has come
                in_valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            send_beat(pick_operation(), pick_value(), 1);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DEPTH * DEPTH + 20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard limit: far above the slowest correct run.
    initial begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

endmodule
